### hdl/assert_macros.svh
// Assertion macros used by the checker file of the in-circle block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/ic_pkg.sv
// Package with the shared constants of the in-circle predicate block.
package ic_pkg;

	// Default coordinate width in bits.
	localparam int DEF_COORD_WIDTH = 16;

	// Number of register stages from the input transfer to the result register.
	localparam int PIPE_DEPTH = 7;

	// Codes of the position result.
	localparam logic signed [1:0] POS_INSIDE  = 2'sb01;
	localparam logic signed [1:0] POS_ON      = 2'sb00;
	localparam logic signed [1:0] POS_OUTSIDE = 2'sb11;

endpackage

### hdl/incircle_predicate.sv
// In-circle predicate: a seven-stage pipeline that evaluates the lifted 4x4 determinant exactly.
//
// Usage:
//   One input transfer (item_valid and item_ready high) carries the four points a, b, c
//   and d. One result transfer (result_valid and result_ready high) returns position:
//   1 when d lies inside the circle through a, b and c, 0 on it, -1 outside. A clockwise
//   a, b, c is treated as if a and b were swapped.
// Pipeline:
//   An accepted item passes through stages 1 to 7 in order; result_valid is the valid bit of
//   stage 7. One item is accepted in every cycle while item_ready is high. In the pipeline,
//   stage 1 forms coordinate differences, stage 2 their products, stage 3 the lifted terms
//   and minors, stage 4 the split partial products, stage 5 the full products, stage 6 the
//   determinant, and stage 7 holds the result.
// Stalls:
//   When result_ready is low the output stage holds its result and the stages behind it
//   keep filling empty slots. item_ready falls only when every stage holds an item.
// Reset:
//   arst_n clears all stage valid bits at once. The block accepts items right after.
module incircle_predicate #(
	parameter int COORD_WIDTH = ic_pkg::DEF_COORD_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic signed [COORD_WIDTH-1:0] a_x,
	input  logic signed [COORD_WIDTH-1:0] a_y,
	input  logic signed [COORD_WIDTH-1:0] b_x,
	input  logic signed [COORD_WIDTH-1:0] b_y,
	input  logic signed [COORD_WIDTH-1:0] c_x,
	input  logic signed [COORD_WIDTH-1:0] c_y,
	input  logic signed [COORD_WIDTH-1:0] d_x,
	input  logic signed [COORD_WIDTH-1:0] d_y,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic signed [1:0]             position
);

	// Widths of the intermediate values.
	localparam int DW   = COORD_WIDTH + 1;   // coordinate difference
	localparam int PW   = 2 * DW;            // product of two differences
	localparam int SW   = 2 * COORD_WIDTH + 3; // lifted term and 2x2 minor
	localparam int LH   = COORD_WIDTH + 1;   // low part of a split operand
	localparam int HW   = SW - LH;           // high part of a split operand
	localparam int TW   = 2 * SW;            // full product of lifted term and minor
	localparam int DETW = TW + 2;            // determinant
	localparam int NS   = ic_pkg::PIPE_DEPTH;

	// Stage valid bits and advance enables.
	logic [NS:1] vld_q;
	logic [NS:1] en;

	// Stage 1: differences to d (adx, ady, bdx, bdy, cdx, cdy) and edges from a.
	logic signed [DW-1:0] diff_s1 [0:5];
	logic signed [DW-1:0] edge_s1 [0:3];

	// Stage 2: squares, cross products and orientation products.
	logic signed [PW-1:0] sq_s2 [0:5];
	logic signed [PW-1:0] cr_s2 [0:5];
	logic signed [PW-1:0] or_s2 [0:1];

	// Stage 3: lifted terms al, bl, cl and the matching minors, orientation flag.
	logic signed [SW-1:0] lift_s3  [0:2];
	logic signed [SW-1:0] minor_s3 [0:2];
	logic                 neg_s3;
	logic signed [SW-1:0] orient;

	// Stage 4: partial products of the split operands.
	logic        [2*LH-1:0]    pll_s4 [0:2];
	logic signed [HW+LH:0]     plh_s4 [0:2];
	logic signed [HW+LH:0]     phl_s4 [0:2];
	logic signed [2*HW-1:0]    phh_s4 [0:2];
	logic                      neg_s4;
	logic        [LH-1:0]      lift_lo [0:2];
	logic signed [HW-1:0]      lift_hi [0:2];
	logic        [LH-1:0]      minor_lo [0:2];
	logic signed [HW-1:0]      minor_hi [0:2];

	// Stage 5: full products; stage 6: determinant; stage 7: result.
	logic signed [TW-1:0]   term_s5 [0:2];
	logic                   neg_s5;
	logic signed [DETW-1:0] det_s6;
	logic                   neg_s6;
	logic signed [1:0]      pos_s7;
	logic                   det_neg;
	logic                   det_nz;
	logic signed [1:0]      pos_next;

	// A stage moves when it is empty or the stage after it moves.
	always_comb begin
		en[NS] = !vld_q[NS] || result_ready;
		for (int k = NS - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign item_ready   = en[1];
	assign result_valid = vld_q[NS];
	assign position     = pos_s7;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= item_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Stage 1: translate by -d and take the edge vectors for the orientation.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			diff_s1[0] <= DW'(a_x) - DW'(d_x);
			diff_s1[1] <= DW'(a_y) - DW'(d_y);
			diff_s1[2] <= DW'(b_x) - DW'(d_x);
			diff_s1[3] <= DW'(b_y) - DW'(d_y);
			diff_s1[4] <= DW'(c_x) - DW'(d_x);
			diff_s1[5] <= DW'(c_y) - DW'(d_y);
			edge_s1[0] <= DW'(b_x) - DW'(a_x);
			edge_s1[1] <= DW'(b_y) - DW'(a_y);
			edge_s1[2] <= DW'(c_x) - DW'(a_x);
			edge_s1[3] <= DW'(c_y) - DW'(a_y);
		end
	end

	// Stage 2: the products of two differences.
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < 6; i++) begin
				sq_s2[i] <= PW'(diff_s1[i]) * PW'(diff_s1[i]);
			end
			cr_s2[0] <= PW'(diff_s1[2]) * PW'(diff_s1[5]); // bdx * cdy
			cr_s2[1] <= PW'(diff_s1[3]) * PW'(diff_s1[4]); // bdy * cdx
			cr_s2[2] <= PW'(diff_s1[1]) * PW'(diff_s1[4]); // ady * cdx
			cr_s2[3] <= PW'(diff_s1[0]) * PW'(diff_s1[5]); // adx * cdy
			cr_s2[4] <= PW'(diff_s1[0]) * PW'(diff_s1[3]); // adx * bdy
			cr_s2[5] <= PW'(diff_s1[1]) * PW'(diff_s1[2]); // ady * bdx
			or_s2[0] <= PW'(edge_s1[0]) * PW'(edge_s1[3]);
			or_s2[1] <= PW'(edge_s1[1]) * PW'(edge_s1[2]);
		end
	end

	// Stage 3: lifted terms, minors, and whether the circle points turn clockwise.
	assign orient = SW'(or_s2[0]) - SW'(or_s2[1]);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int k = 0; k < 3; k++) begin
				lift_s3[k]  <= SW'(sq_s2[2*k]) + SW'(sq_s2[2*k+1]);
				minor_s3[k] <= SW'(cr_s2[2*k]) - SW'(cr_s2[2*k+1]);
			end
			neg_s3 <= orient[SW-1];
		end
	end

	// Stage 4: split both operands into a signed high and an unsigned low part.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			lift_lo[k]  = lift_s3[k][LH-1:0];
			lift_hi[k]  = lift_s3[k][SW-1:LH];
			minor_lo[k] = minor_s3[k][LH-1:0];
			minor_hi[k] = minor_s3[k][SW-1:LH];
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int k = 0; k < 3; k++) begin
				pll_s4[k] <= (2 * LH)'(lift_lo[k]) * (2 * LH)'(minor_lo[k]);
				plh_s4[k] <= (HW + LH + 1)'(minor_hi[k])
					* (HW + LH + 1)'($signed({1'b0, lift_lo[k]}));
				phl_s4[k] <= (HW + LH + 1)'(lift_hi[k])
					* (HW + LH + 1)'($signed({1'b0, minor_lo[k]}));
				phh_s4[k] <= (2 * HW)'(lift_hi[k]) * (2 * HW)'(minor_hi[k]);
			end
			neg_s4 <= neg_s3;
		end
	end

	// Stage 5: reassemble each full product from its partial products.
	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int k = 0; k < 3; k++) begin
				term_s5[k] <= (TW'(phh_s4[k]) <<< (2 * LH))
					+ ((TW'(plh_s4[k]) + TW'(phl_s4[k])) <<< LH)
					+ TW'(pll_s4[k]);
			end
			neg_s5 <= neg_s4;
		end
	end

	// Stage 6: the determinant is the sum of the three products.
	always_ff @(posedge clk) begin
		if (en[6]) begin
			det_s6 <= DETW'(term_s5[0]) + DETW'(term_s5[1]) + DETW'(term_s5[2]);
			neg_s6 <= neg_s5;
		end
	end

	// Stage 7: sign of the determinant, flipped for a clockwise triangle.
	assign det_neg = det_s6[DETW-1];
	assign det_nz  = |det_s6;

	always_comb begin
		if (det_neg) begin
			pos_next = neg_s6 ? ic_pkg::POS_INSIDE : ic_pkg::POS_OUTSIDE;
		end else if (det_nz) begin
			pos_next = neg_s6 ? ic_pkg::POS_OUTSIDE : ic_pkg::POS_INSIDE;
		end else begin
			pos_next = ic_pkg::POS_ON;
		end
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			pos_s7 <= pos_next;
		end
	end

endmodule

### hdl/ic_check.sv
// Port checker for the in-circle predicate block and its bind statement.
`include "assert_macros.svh"

module ic_check #(
	parameter int COORD_WIDTH = ic_pkg::DEF_COORD_WIDTH
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          item_valid,
	input logic                          item_ready,
	input logic signed [COORD_WIDTH-1:0] a_x,
	input logic signed [COORD_WIDTH-1:0] a_y,
	input logic signed [COORD_WIDTH-1:0] d_x,
	input logic signed [COORD_WIDTH-1:0] d_y,
	input logic                          result_valid,
	input logic                          result_ready,
	input logic signed [1:0]             position
);

	localparam int NS = ic_pkg::PIPE_DEPTH;

	// History of input transfers, of transfers with d on a, and of result_ready.
	logic [NS-1:0] acc_q;
	logic [NS-1:0] on_q;
	logic [NS-2:0] rdy_q;
	logic          acc_now;
	logic          through;
	logic          pos_legal;

	assign acc_now   = item_valid && item_ready;
	assign through   = acc_q[NS-1] && (&rdy_q);
	assign pos_legal = (position == ic_pkg::POS_INSIDE) || (position == ic_pkg::POS_ON)
		|| (position == ic_pkg::POS_OUTSIDE);

	// Shift the histories by one each cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			on_q  <= '0;
			rdy_q <= '0;
		end else begin
			acc_q <= {acc_q[NS-2:0], acc_now};
			on_q  <= {on_q[NS-2:0], acc_now && (d_x == a_x) && (d_y == a_y)};
			rdy_q <= {rdy_q[NS-3:0], result_ready};
		end
	end

	`ASSERT_IMP(a_pos_legal, clk, arst_n, result_valid, pos_legal, "illegal position code")
	`ASSERT_NXT(a_stall_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(position), "stalled result changed")
	`ASSERT_IMP(a_empty_ready, clk, arst_n, !result_valid, item_ready, "input blocked while output empty")
	`ASSERT_IMP(a_latency, clk, arst_n, through, result_valid, "result missing after pipeline latency")
	`ASSERT_IMP(a_on_circle, clk, arst_n, through && on_q[NS-1], position == ic_pkg::POS_ON, "query on a circle point not reported on")

endmodule

bind incircle_predicate ic_check #(.COORD_WIDTH(COORD_WIDTH)) u_ic_check (.*);
